FILE: hdl/histogram_contrast_stretch_macros.svh
`ifndef HISTOGRAM_CONTRAST_STRETCH_MACROS_SVH
`define HISTOGRAM_CONTRAST_STRETCH_MACROS_SVH

`ifndef SYNTHESIS
`define HCS_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");
`define HCS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define HCS_ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define HCS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

FILE: hdl/hcs_pkg.sv
package hcs_pkg;

  localparam int PIXEL_BITS  = 8;
  localparam int OUT_BITS    = 8;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  localparam logic [1:0] REQ_CLEAR = 2'd0;
  localparam logic [1:0] REQ_SCAN  = 2'd1;
  localparam logic [1:0] REQ_MAP   = 2'd2;

  typedef logic [PIXEL_BITS-1:0] pix_t;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] pixel_in;
  } in_word_t;

  typedef struct packed {
    logic [7:0] pixel_out;
    logic       flat_image;
  } out_word_t;

  typedef struct packed {
    logic flat;
    pix_t off;
    pix_t span;
  } map_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

FILE: hdl/hcs_queue.sv
`include "histogram_contrast_stretch_macros.svh"

module hcs_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  hcs_pkg::map_cmd_t wdata,
  input  logic              pop,
  output hcs_pkg::map_cmd_t rdata,
  output hcs_pkg::q_stat_t  stat
);
  import hcs_pkg::*;

  map_cmd_t               mem_r [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_BITS-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_BITS-1:0]   cnt_r, cnt_nxt;
  logic                   do_push, do_pop;

  assign stat.full  = (cnt_r == QCNT_BITS'(QUEUE_DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign rdata      = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  `HCS_ASSERT_NEXT(a_q_full_push_holds, clk, rst_n, push && stat.full && !pop, $stable(cnt_r))
  `HCS_ASSERT_SAME(a_q_count_bound, clk, rst_n, 1'b1, cnt_r <= QCNT_BITS'(QUEUE_DEPTH))

endmodule

FILE: hdl/hcs_front.sv
`include "histogram_contrast_stretch_macros.svh"

module hcs_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  hcs_pkg::in_word_t in_word,
  input  hcs_pkg::q_stat_t  q_stat,
  output logic              q_push,
  output hcs_pkg::map_cmd_t q_wdata
);
  import hcs_pkg::*;

  pix_t dark_r, dark_nxt;
  pix_t bright_r, bright_nxt;
  pix_t pix, clamped;
  logic accept;

  assign accept = push && !q_stat.full;
  assign pix    = PIXEL_BITS'(in_word.pixel_in);

  always_comb begin
    clamped = pix;
    if (clamped < dark_r) begin
      clamped = dark_r;
    end
    if (clamped > bright_r) begin
      clamped = bright_r;
    end
  end

  assign q_wdata.flat = (bright_r <= dark_r);
  assign q_wdata.off  = clamped - dark_r;
  assign q_wdata.span = bright_r - dark_r;

  always_comb begin
    dark_nxt   = dark_r;
    bright_nxt = bright_r;
    q_push     = 1'b0;
    if (accept) begin
      case (in_word.req_type)
        REQ_CLEAR: begin
          dark_nxt   = '1;
          bright_nxt = '0;
        end
        REQ_SCAN: begin
          if (pix < dark_r) begin
            dark_nxt = pix;
          end
          if (pix > bright_r) begin
            bright_nxt = pix;
          end
        end
        REQ_MAP: begin
          q_push = 1'b1;
        end
        default: begin
          q_push = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dark_r   <= '1;
      bright_r <= '0;
    end else begin
      dark_r   <= dark_nxt;
      bright_r <= bright_nxt;
    end
  end

  `HCS_ASSERT_NEXT(a_scan_orders_range, clk, rst_n, accept && in_word.req_type == REQ_SCAN, dark_r <= bright_r)

endmodule

FILE: hdl/hcs_back.sv
`include "histogram_contrast_stretch_macros.svh"

module hcs_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [7:0]         out_max,
  input  hcs_pkg::q_stat_t   q_stat,
  input  hcs_pkg::map_cmd_t  q_rdata,
  output logic               q_pop,
  output logic               res_valid,
  input  logic               res_pop,
  output hcs_pkg::out_word_t res
);
  import hcs_pkg::*;

  localparam int PROD_W = PIXEL_BITS + 8;
  localparam int DW     = PIXEL_BITS + 10;
  localparam int CNT_W  = $clog2(OUT_BITS);

  typedef enum logic [2:0] {B_IDLE, B_MUL, B_LOAD, B_DIV, B_HOLD} bstate_t;

  bstate_t             state_r;
  map_cmd_t            cmd_r;
  logic [PROD_W-1:0]   prod_r;
  logic [DW-1:0]       rem_r;
  logic [DW-1:0]       dsh_r;
  logic [OUT_BITS-1:0] quo_r;
  logic [CNT_W-1:0]    cnt_r;
  out_word_t           res_r;
  logic                ge;

  assign q_pop     = (state_r == B_IDLE) && !q_stat.empty;
  assign res_valid = (state_r == B_HOLD);
  assign res       = res_r;
  assign ge        = (rem_r >= dsh_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
    end else begin
      case (state_r)
        B_IDLE: begin
          if (!q_stat.empty) begin
            cmd_r <= q_rdata;
            if (q_rdata.flat) begin
              res_r.pixel_out  <= '0;
              res_r.flat_image <= 1'b1;
              state_r          <= B_HOLD;
            end else begin
              state_r <= B_MUL;
            end
          end
        end
        B_MUL: begin
          prod_r  <= PROD_W'(cmd_r.off) * PROD_W'(out_max);
          state_r <= B_LOAD;
        end
        B_LOAD: begin
          rem_r   <= (DW'(prod_r) << 1) + DW'(cmd_r.span);
          dsh_r   <= DW'(cmd_r.span) << OUT_BITS;
          cnt_r   <= CNT_W'(OUT_BITS - 1);
          quo_r   <= '0;
          state_r <= B_DIV;
        end
        B_DIV: begin
          if (ge) begin
            rem_r <= rem_r - dsh_r;
          end
          dsh_r <= dsh_r >> 1;
          quo_r <= {quo_r[OUT_BITS-2:0], ge};
          cnt_r <= cnt_r - 1'b1;
          if (cnt_r == '0) begin
            res_r.pixel_out  <= 8'({quo_r[OUT_BITS-2:0], ge});
            res_r.flat_image <= 1'b0;
            state_r          <= B_HOLD;
          end
        end
        B_HOLD: begin
          if (res_pop) begin
            state_r <= B_IDLE;
          end
        end
        default: begin
          state_r <= B_IDLE;
        end
      endcase
    end
  end

  `HCS_ASSERT_NEXT(a_hold_stable, clk, rst_n, state_r == B_HOLD && !res_pop, state_r == B_HOLD && $stable(res_r))
  `HCS_ASSERT_NEXT(a_div_within_top, clk, rst_n, state_r == B_DIV && cnt_r == '0, !res_r.flat_image && res_r.pixel_out <= out_max)

endmodule

FILE: hdl/histogram_contrast_stretch.sv
// Min-max contrast stretch of a grey image in two passes. A clear word resets the darkest and
// brightest seen levels, a scan word widens that range by one pixel, and a map word returns
// round((p - darkest) * out_max / (brightest - darkest)) rounded half up, with the pixel first
// saturated into the seen range; a flat or unscanned range returns 0 with flat_image set.
// Only map words give a result; clear, scan and unused codes give none. Clear and scan words
// are handled in the front alone. Each map word waits in a 4-entry command queue, then passes
// through the back end: queue pop, one multiply, one load, 8 steps of the restoring divider and
// a hold until popped; flat maps skip multiply, load and divider. The front takes words until
// the command queue fills; the back end pops a map word only once the last result is popped.
// The user writes out_max via cfg_we and cfg_wdata only while idle; the block won't check it.
module histogram_contrast_stretch (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  hcs_pkg::in_word_t  in_word,
  output logic               empty,
  input  logic               pop,
  output hcs_pkg::out_word_t out_word,
  input  logic               cfg_we,
  input  logic [7:0]         cfg_wdata
);
  import hcs_pkg::*;

  logic [7:0] out_max_r;
  q_stat_t    q_stat;
  logic       q_push, q_pop, res_valid;
  map_cmd_t   q_wdata, q_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_max_r <= 8'd255;
    end else if (cfg_we) begin
      out_max_r <= cfg_wdata;
    end
  end

  assign full  = q_stat.full;
  assign empty = !res_valid;

  hcs_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .in_word (in_word),
    .q_stat  (q_stat),
    .q_push  (q_push),
    .q_wdata (q_wdata)
  );

  hcs_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .stat  (q_stat)
  );

  hcs_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_max   (out_max_r),
    .q_stat    (q_stat),
    .q_rdata   (q_rdata),
    .q_pop     (q_pop),
    .res_valid (res_valid),
    .res_pop   (pop),
    .res       (out_word)
  );

endmodule

FILE: sim/histogram_contrast_stretch_test.sv
module histogram_contrast_stretch_test;
  timeunit 1ns;
  timeprecision 1ps;

  import hcs_pkg::*;

  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int ITEMS_PER_SETTING = 155;
  localparam int SETTLE_CYCLES = 64;
  localparam int CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic push = 1'b0;
  logic full;
  in_word_t in_word = '0;
  logic empty;
  logic pop = 1'b0;
  out_word_t out_word;
  logic cfg_we = 1'b0;
  logic [7:0] cfg_wdata = '0;

  in_word_t pending_words[$];
  out_word_t expected_levels[$];

  pix_t darkest = '1;
  pix_t brightest = '0;
  logic [7:0] out_max_level = 8'd255;

  int gap_left = 0;
  int burst_left = 0;
  bit [31:0] stall_tick = '0;
  int cycle_count = 0;
  int errors = 0;
  int words_sent = 0;
  int levels_checked = 0;
  int flat_seen = 0;
  int settings_written = 0;

  histogram_contrast_stretch dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .in_word  (in_word),
    .empty    (empty),
    .pop      (pop),
    .out_word (out_word),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  function automatic void queue_word(input logic [1:0] kind, input logic [7:0] pix);
    in_word_t w;
    w.req_type = kind;
    w.pixel_in = pix;
    pending_words.push_back(w);
  endfunction

  function automatic void predict_stretch(input in_word_t w);
    pix_t p;
    int unsigned span;
    int unsigned scaled;
    out_word_t lvl;
    p = w.pixel_in[PIXEL_BITS-1:0];
    case (w.req_type)
      REQ_CLEAR: begin
        darkest = '1;
        brightest = '0;
      end
      REQ_SCAN: begin
        if (p < darkest) darkest = p;
        if (p > brightest) brightest = p;
      end
      REQ_MAP: begin
        if (brightest <= darkest) begin
          lvl.pixel_out = '0;
          lvl.flat_image = 1'b1;
        end else begin
          if (p < darkest) p = darkest;
          if (p > brightest) p = brightest;
          span = 32'(brightest - darkest);
          scaled = 32'(p - darkest) * 32'(out_max_level);
          lvl.pixel_out = 8'((2 * scaled + span) / (2 * span));
          lvl.flat_image = 1'b0;
        end
        expected_levels.push_back(lvl);
      end
      default: begin
      end
    endcase
  endfunction

  task automatic write_out_max(input logic [7:0] value);
    @(posedge clk);
    cfg_wdata <= value;
    cfg_we <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
    out_max_level = value;
    settings_written++;
  endtask

  task automatic wait_idle();
    while (pending_words.size() != 0 || push || expected_levels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // well-formed images with random content, mixed with stray and broken requests
  task automatic add_images(input int target);
    int added;
    int lo;
    int hi;
    int n_scan;
    int n_map;
    int k;
    added = 0;
    while (added < target) begin
      case ($urandom_range(0, 9))
        0: begin
          queue_word(REQ_UNUSED, 8'($urandom_range(0, 255)));
        end
        1: begin
          queue_word($urandom_range(0, 1) ? REQ_MAP : REQ_SCAN, 8'($urandom_range(0, 255)));
          added++;
        end
        2: begin
          queue_word(REQ_CLEAR, 8'($urandom_range(0, 255)));
          n_map = $urandom_range(1, 3);
          for (k = 0; k < n_map; k++) queue_word(REQ_MAP, 8'($urandom_range(0, 255)));
          added += 1 + n_map;
        end
        default: begin
          lo = $urandom_range(0, 255);
          hi = lo + (($urandom_range(0, 3) == 0) ? $urandom_range(0, 4) : $urandom_range(0, 255));
          if (hi > 255) hi = 255;
          queue_word(REQ_CLEAR, 8'($urandom_range(0, 255)));
          n_scan = $urandom_range(0, 8);
          if ($urandom_range(0, 1)) begin
            queue_word(REQ_SCAN, 8'(lo));
            queue_word(REQ_SCAN, 8'(hi));
          end else begin
            queue_word(REQ_SCAN, 8'(hi));
            queue_word(REQ_SCAN, 8'(lo));
          end
          for (k = 0; k < n_scan; k++) queue_word(REQ_SCAN, 8'($urandom_range(lo, hi)));
          n_map = $urandom_range(1, 12);
          for (k = 0; k < n_map; k++) begin
            if ($urandom_range(0, 15) == 0) queue_word(REQ_SCAN, 8'($urandom_range(0, 255)));
            if ($urandom_range(0, 3) == 0) queue_word(REQ_MAP, 8'($urandom_range(0, 255)));
            else queue_word(REQ_MAP, 8'($urandom_range(lo, hi)));
          end
          added += 3 + n_scan + n_map;
        end
      endcase
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        predict_stretch(in_word);
        words_sent++;
      end
      if (!(push && full)) begin
        if (gap_left > 0) begin
          gap_left--;
          push <= 1'b0;
        end else if (pending_words.size() > 0) begin
          in_word <= pending_words.pop_front();
          push <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(0, 12);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (expected_levels.size() == 0) begin
          $display("%0t unexpected word: pixel_out %0d flat_image %0b", $time,
                   out_word.pixel_out, out_word.flat_image);
          errors++;
        end else begin
          if (out_word.pixel_out !== expected_levels[0].pixel_out) begin
            $display("%0t pixel_out expected %0d actual %0d", $time,
                     expected_levels[0].pixel_out, out_word.pixel_out);
            errors++;
          end
          if (out_word.flat_image !== expected_levels[0].flat_image) begin
            $display("%0t flat_image expected %0b actual %0b", $time,
                     expected_levels[0].flat_image, out_word.flat_image);
            errors++;
          end
          if (expected_levels[0].flat_image) flat_seen++;
          void'(expected_levels.pop_front());
          levels_checked++;
        end
      end
      stall_tick++;
      case (stall_tick[8:7])
        2'd0: pop <= 1'b1;
        2'd1: pop <= 1'($urandom_range(0, 1));
        2'd2: pop <= (stall_tick % 6 == 0);
        default: pop <= (stall_tick % 3 != 0);
      endcase
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    logic [7:0] out_max_plan[6];
    int i;
    out_max_plan[0] = 8'd1;
    out_max_plan[1] = 8'd0;
    out_max_plan[2] = 8'd255;
    out_max_plan[3] = 8'd128;
    out_max_plan[4] = 8'($urandom_range(1, 254));
    out_max_plan[5] = 8'($urandom_range(1, 254));

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // map before any scan, then single-level and full ranges at reset out_max
    queue_word(REQ_MAP, 8'h80);
    queue_word(REQ_UNUSED, 8'hFF);
    queue_word(REQ_MAP, 8'hFF);
    queue_word(REQ_SCAN, 8'd255);
    queue_word(REQ_MAP, 8'd255);
    queue_word(REQ_SCAN, 8'd0);
    queue_word(REQ_MAP, 8'd0);
    queue_word(REQ_MAP, 8'd255);
    queue_word(REQ_MAP, 8'd128);
    queue_word(REQ_MAP, 8'd127);
    queue_word(REQ_MAP, 8'h55);
    queue_word(REQ_MAP, 8'hAA);
    queue_word(REQ_CLEAR, 8'hFF);
    queue_word(REQ_MAP, 8'd0);
    queue_word(REQ_SCAN, 8'd100);
    queue_word(REQ_SCAN, 8'd100);
    queue_word(REQ_MAP, 8'd100);
    queue_word(REQ_SCAN, 8'd101);
    queue_word(REQ_MAP, 8'd0);
    queue_word(REQ_MAP, 8'd255);
    queue_word(REQ_MAP, 8'd100);
    queue_word(REQ_MAP, 8'd101);
    queue_word(REQ_UNUSED, 8'h00);
    queue_word(REQ_MAP, 8'd101);
    wait_idle();

    for (i = 0; i < 6; i++) begin
      write_out_max(out_max_plan[i]);
      add_images(ITEMS_PER_SETTING);
      wait_idle();
    end

    $display("Sent %0d words over %0d out_max settings plus the reset value;", words_sent,
             settings_written);
    $display("checked %0d stretched levels, %0d of them flat.", levels_checked, flat_seen);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
